/* sv/fwsm_pkg.sv */
`default_nettype none
package fwsm_pkg;

	localparam int MAX_REACH_DEF  = 8;
	localparam int MAX_LENGTH_DEF = 65536;

	localparam int SAMPLE_W = 32;
	localparam int POS_W    = 17;
	localparam int IDX_W    = 16;
	localparam int REACH_W  = 4;

	localparam logic [REACH_W-1:0] REACH_RST = 4'd1;

	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_SEL_W = PADDR_W - 2;

	// Register map, one 32-bit word per register.
	typedef enum logic [REG_SEL_W-1:0] {
		REG_REACH = 1'b0
	} reg_sel_t;

	// No minimum in the sequence.
	localparam logic signed [POS_W-1:0] POS_NONE = '1;

	typedef struct packed {
		logic                    emit;
		logic signed [POS_W-1:0] position;
		logic                    found;
	} result_t;

endpackage
`default_nettype wire

/* sv/fwsm_in_if.sv */
`default_nettype none
interface fwsm_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [fwsm_pkg::SAMPLE_W-1:0]   sample;
	logic                                   last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface
`default_nettype wire

/* sv/fwsm_out_if.sv */
`default_nettype none
interface fwsm_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [fwsm_pkg::POS_W-1:0]   position;
	logic                                found;

	modport source (output valid, output position, output found, input ready);
	modport sink (input valid, input position, input found, output ready);
endinterface
`default_nettype wire

/* sv/fwsm_cfg.sv */
`default_nettype none
module fwsm_cfg #(
	parameter int MAX_REACH = fwsm_pkg::MAX_REACH_DEF,
	localparam int RW = $clog2(MAX_REACH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fwsm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [fwsm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [fwsm_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output logic      [RW-1:0]                 reach
);

	localparam int CMPW = (RW > fwsm_pkg::REACH_W) ? RW : fwsm_pkg::REACH_W;

	logic [fwsm_pkg::REACH_W-1:0] reach_q;
	logic                         sel_reach;

	always_comb begin
		unique case (fwsm_pkg::reg_sel_t'(paddr[fwsm_pkg::PADDR_W-1:2]))
			fwsm_pkg::REG_REACH: sel_reach = 1'b1;
			default:             sel_reach = 1'b0;
		endcase
	end

	assign pready = 1'b1;
	assign prdata = sel_reach ? fwsm_pkg::PDATA_W'(reach_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= fwsm_pkg::REACH_RST;
		end else if (psel && penable && pwrite && pready && sel_reach) begin
			reach_q <= pwdata[fwsm_pkg::REACH_W-1:0];
		end
	end

	// Zero behaves as one, anything above MAX_REACH saturates.
	always_comb begin
		if (reach_q == '0) begin
			reach = RW'(1);
		end else if (CMPW'(reach_q) > CMPW'(MAX_REACH)) begin
			reach = RW'(MAX_REACH);
		end else begin
			reach = RW'(reach_q);
		end
	end

endmodule
`default_nettype wire

/* sv/fwsm_scan.sv */
`default_nettype none
module fwsm_scan #(
	parameter int MAX_REACH  = fwsm_pkg::MAX_REACH_DEF,
	parameter int MAX_LENGTH = fwsm_pkg::MAX_LENGTH_DEF,
	localparam int RW = $clog2(MAX_REACH + 1)
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 step,
	input  wire logic signed [fwsm_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                 last,
	input  wire logic        [RW-1:0]                 reach,
	output fwsm_pkg::result_t                         res
);

	localparam int DEPTH = 2 * MAX_REACH;
	localparam int WIW   = $clog2(2 * MAX_REACH + 1);
	localparam int SW    = $clog2(MAX_LENGTH + 1);
	localparam int CW    = (SW > WIW) ? SW + 1 : WIW + 1;
	localparam int DW0   = (SW > RW) ? SW : RW;
	localparam int DW    = ((DW0 > fwsm_pkg::IDX_W) ? DW0 : fwsm_pkg::IDX_W) + 1;

	logic signed [fwsm_pkg::SAMPLE_W-1:0] window_q [DEPTH];
	logic signed [fwsm_pkg::SAMPLE_W-1:0] nw [DEPTH+1];
	logic signed [fwsm_pkg::SAMPLE_W-1:0] mid;
	logic [SW-1:0]               seen_q;
	logic [SW-1:0]               seen_new;
	logic [fwsm_pkg::IDX_W-1:0]  first_q;
	logic [fwsm_pkg::IDX_W-1:0]  first_new;
	logic [fwsm_pkg::IDX_W-1:0]  idx;
	logic [DW-1:0]               diff;
	logic                        have_q;
	logic                        have_new;
	logic                        take;
	logic                        enough;
	logic                        ok;
	logic                        hit;
	logic [WIW-1:0]              r_idx;
	logic [WIW-1:0]              twice_r;

	assign take     = seen_q < SW'(MAX_LENGTH);
	assign seen_new = seen_q + SW'(1);
	assign r_idx    = WIW'(reach);
	assign twice_r  = WIW'({reach, 1'b0});
	assign enough   = CW'(seen_new) >= (CW'(twice_r) + CW'(1));

	always_comb begin
		nw[0] = sample;
		for (int i = 1; i <= DEPTH; i++) begin
			nw[i] = window_q[i-1];
		end
	end

	assign mid = nw[r_idx];

	// Comparator bank: the middle sample must be below every sample within reach.
	always_comb begin
		ok = 1'b1;
		for (int i = 0; i <= DEPTH; i++) begin
			if ((WIW'(i) <= twice_r) && (WIW'(i) != r_idx) && !(mid < nw[i])) begin
				ok = 1'b0;
			end
		end
	end

	assign hit       = take && !have_q && enough && ok;
	assign diff      = DW'(seen_q) - DW'(reach);
	assign idx       = diff[fwsm_pkg::IDX_W-1:0];
	assign have_new  = have_q || hit;
	assign first_new = hit ? idx : first_q;

	always_comb begin
		res.emit     = step && last;
		res.found    = have_new;
		res.position = have_new ? $signed({1'b0, first_new}) : fwsm_pkg::POS_NONE;
	end

	always_ff @(posedge clk) begin
		if (step && take) begin
			for (int i = 0; i < DEPTH; i++) begin
				window_q[i] <= nw[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			have_q  <= 1'b0;
			first_q <= '0;
		end else if (step) begin
			if (last) begin
				seen_q  <= '0;
				have_q  <= 1'b0;
				first_q <= '0;
			end else begin
				if (take) begin
					seen_q <= seen_new;
				end
				have_q  <= have_new;
				first_q <= first_new;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/first_window_strict_minimum_core.sv */
`default_nettype none
// Finds the first strict local minimum of a stream of signed 32-bit samples. Each
// sequence ends with a beat that has last set; that beat produces one result beat
// carrying the index of the first sample that is strictly below its reach
// neighbors on both sides (found set), or -1 with found clear. The block takes one
// sample beat per cycle, except that a last beat waits while the result register
// is full and not being drained. The last beat is registered in the input stage,
// and its result in the result register. The rate rests on the combinational
// comparator bank that tests the middle of the shift window against all 2*reach
// neighbors in parallel. The reach register (APB address 0) must only be written
// while no sequence is in flight; zero behaves as one and values above MAX_REACH
// saturate. Samples past MAX_LENGTH in one sequence are ignored until last arrives.
module first_window_strict_minimum_core #(
	parameter int MAX_REACH  = fwsm_pkg::MAX_REACH_DEF,
	parameter int MAX_LENGTH = fwsm_pkg::MAX_LENGTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	fwsm_in_if.sink                            in_ch,
	fwsm_out_if.source                         out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [fwsm_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [fwsm_pkg::PDATA_W-1:0]  pwdata,
	output logic      [fwsm_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);

	localparam int RW = $clog2(MAX_REACH + 1);

	logic                                 valid_s1;
	logic signed [fwsm_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                 last_s1;
	logic                                 valid_s2;
	logic signed [fwsm_pkg::POS_W-1:0]    position_s2;
	logic                                 found_s2;
	logic                                 advance;
	logic [RW-1:0]                        reach;
	fwsm_pkg::result_t                    res;

	// A beat without last never produces a result, so it moves on even when the
	// result register is full.
	assign advance     = valid_s1 && (!last_s1 || !valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	fwsm_cfg #(
		.MAX_REACH (MAX_REACH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.reach   (reach)
	);

	fwsm_scan #(
		.MAX_REACH  (MAX_REACH),
		.MAX_LENGTH (MAX_LENGTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.last   (last_s1),
		.reach  (reach),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			sample_s1 <= in_ch.sample;
			last_s1   <= in_ch.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (res.emit) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) begin
			position_s2 <= res.position;
			found_s2    <= res.found;
		end
	end

	assign out_ch.valid    = valid_s2;
	assign out_ch.position = position_s2;
	assign out_ch.found    = found_s2;

endmodule
`default_nettype wire

/* sv/fwsm_checker.sv */
`default_nettype none
module fwsm_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic signed [fwsm_pkg::POS_W-1:0]     position,
	input wire logic                                  found,
	input wire logic                                  psel,
	input wire logic                                  penable,
	input wire logic                                  pwrite,
	input wire logic        [fwsm_pkg::PADDR_W-1:0]   paddr,
	input wire logic        [fwsm_pkg::PDATA_W-1:0]   pwdata,
	input wire logic        [fwsm_pkg::PDATA_W-1:0]   prdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(position) && $stable(found))
		else $error("result payload changed while stalled");

	a_none_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == fwsm_pkg::POS_NONE)
		else $error("missing minimum not reported as -1");

	a_found_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !position[fwsm_pkg::POS_W-1])
		else $error("found minimum with negative position");

	// The reach register reads back the low nibble of the last write.
	a_reach_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == '0
		|=> (paddr != '0) || (prdata == fwsm_pkg::PDATA_W'($past(pwdata[fwsm_pkg::REACH_W-1:0]))))
		else $error("reach register read-back mismatch");

endmodule

bind first_window_strict_minimum_core fwsm_checker u_fwsm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.position  (out_ch.position),
	.found     (out_ch.found),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import fwsm_pkg::*;

	localparam int WIN_DEPTH = 2 * MAX_REACH_DEF + 1;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} sample_beat_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic                    found;
	} minimum_report_t;

	typedef enum int {FILL_NARROW, FILL_WIDE, FILL_EDGE, FILL_DIPS} fill_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	wire  [PDATA_W-1:0]  prdata;
	wire                 pready;

	fwsm_in_if  in_ch();
	fwsm_out_if out_ch();

	first_window_strict_minimum_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sample_beat_t    pending_beats[$];
	minimum_report_t minimum_reports[$];
	minimum_report_t due_report;
	int unsigned     mismatches = 0;
	int unsigned     queued_beats = 0;

	// Shadow of the block: window, sequence progress and the reach register.
	logic signed [SAMPLE_W-1:0] win [WIN_DEPTH];
	int                         seen = 0;
	logic [IDX_W-1:0]           first_idx = '0;
	logic                       matched = 1'b0;
	logic [REACH_W-1:0]         reach_cfg = REACH_RST;

	int burst_left = 1;
	int gap_left = 0;
	int unsigned rx_tick = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int clamp_reach(input logic [REACH_W-1:0] value);
		if (value == 0)
			return 1;
		if (value > MAX_REACH_DEF)
			return MAX_REACH_DEF;
		return int'(value);
	endfunction

	function automatic void track_sample(input logic signed [SAMPLE_W-1:0] s,
			input logic is_last);
		int r;
		logic signed [SAMPLE_W-1:0] mid;
		bit ok;
		minimum_report_t rep;
		if (seen < MAX_LENGTH_DEF) begin
			for (int i = WIN_DEPTH - 1; i > 0; i--)
				win[i] = win[i-1];
			win[0] = s;
			seen++;
			r = clamp_reach(reach_cfg);
			if (!matched && seen >= 2 * r + 1) begin
				mid = win[r];
				ok = 1'b1;
				for (int j = 1; j <= r; j++)
					if (!(mid < win[r-j] && mid < win[r+j]))
						ok = 1'b0;
				if (ok) begin
					first_idx = IDX_W'(seen - 1 - r);
					matched = 1'b1;
				end
			end
		end
		if (is_last) begin
			rep.position = matched ? {1'b0, first_idx} : POS_NONE;
			rep.found = matched;
			minimum_reports.push_back(rep);
			foreach (win[i])
				win[i] = '0;
			seen = 0;
			first_idx = '0;
			matched = 1'b0;
		end
	endfunction

	initial begin
		foreach (win[i])
			win[i] = '0;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				void'(pending_beats.pop_front());
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (pending_beats.size() != 0) begin
					in_ch.valid <= 1'b1;
					in_ch.sample <= pending_beats[0].sample;
					in_ch.last <= pending_beats[0].last;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: a fixed stall pattern with stall-free stretches, plus one long hold-off.
	always @(posedge clk) begin
		if (arst_n) begin
			rx_tick <= rx_tick + 1;
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_left <= HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= rx_tick[9] || (rx_tick % 7 < 4) || (rx_tick % 3 == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (psel && penable && pwrite && pready && paddr == {REG_REACH, 2'b00})
			reach_cfg <= pwdata[REACH_W-1:0];
	end

	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			track_sample(in_ch.sample, in_ch.last);
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (minimum_reports.size() == 0) begin
				$display("%0t: unexpected result beat position %0d found %0b", $time,
					out_ch.position, out_ch.found);
				mismatches++;
			end else begin
				due_report = minimum_reports.pop_front();
				if (out_ch.position !== due_report.position) begin
					$display("%0t: position expected %0d actual %0d", $time,
						due_report.position, out_ch.position);
					mismatches++;
				end
				if (out_ch.found !== due_report.found) begin
					$display("%0t: found expected %0b actual %0b", $time,
						due_report.found, out_ch.found);
					mismatches++;
				end
			end
		end
	end

	task automatic push_beat(input logic signed [SAMPLE_W-1:0] s, input logic is_last);
		sample_beat_t b;
		b.sample = s;
		b.last = is_last;
		pending_beats.push_back(b);
		queued_beats++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] draw_sample(input fill_t fill);
		case (fill)
			FILL_NARROW: return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
			FILL_WIDE: return $urandom;
			FILL_EDGE: begin
				case ($urandom_range(0, 5))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					3: return 32'hFFFF_FFFF;
					4: return 32'h8000_0001;
					default: return 32'h7FFF_FFFE;
				endcase
			end
			default: begin
				// Mostly positive values with scattered shallow dips, some of them tied.
				if ($urandom_range(0, 9) == 0)
					return SAMPLE_W'(-int'($urandom_range(0, 5)));
				return SAMPLE_W'($urandom_range(10, 1000));
			end
		endcase
	endfunction

	task automatic queue_sequence(input int eff_reach);
		int len;
		int pick;
		fill_t fill;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			len = $urandom_range(1, 2 * eff_reach);
		else if (pick == 1)
			len = $urandom_range(60, 150);
		else
			len = $urandom_range(2 * eff_reach + 1, 2 * eff_reach + 20);
		pick = $urandom_range(0, 19);
		if (pick < 5)
			fill = FILL_NARROW;
		else if (pick < 8)
			fill = FILL_WIDE;
		else if (pick < 10)
			fill = FILL_EDGE;
		else
			fill = FILL_DIPS;
		for (int i = 0; i < len; i++)
			push_beat(draw_sample(fill), i == len - 1);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_beats.size() != 0 || in_ch.valid || minimum_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reach(input logic [REACH_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_REACH, 2'b00};
		pwdata <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		logic [REACH_W-1:0] phase_reach [7];
		int eff;
		int unsigned target;
		phase_reach = '{4'd8, 4'd15, 4'd2, 4'd5, 4'd0, 4'd1, 4'd3};
		phase_reach[6] = $urandom_range(0, 15);
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset reach of one: extremes, too-short sequences, ties, first match kept.
		push_beat(32'h7FFF_FFFF, 1'b0);
		push_beat(32'h8000_0000, 1'b0);
		push_beat(32'h7FFF_FFFF, 1'b1);
		push_beat(5, 1'b1);
		push_beat(5, 1'b0);
		push_beat(4, 1'b1);
		repeat (3) push_beat(5, 1'b0);
		push_beat(5, 1'b1);
		push_beat(3, 1'b0);
		push_beat(1, 1'b0);
		push_beat(3, 1'b0);
		push_beat(1, 1'b0);
		push_beat(3, 1'b1);
		push_beat(9, 1'b0);
		push_beat(9, 1'b0);
		push_beat(2, 1'b0);
		push_beat(9, 1'b1);
		push_beat(0, 1'b0);
		push_beat(-1, 1'b0);
		push_beat(0, 1'b1);
		wait_idle();

		// A reach of zero behaves as one.
		write_reach(4'd0);
		push_beat(4, 1'b0);
		push_beat(2, 1'b0);
		push_beat(4, 1'b1);

		foreach (phase_reach[p]) begin
			wait_idle();
			write_reach(phase_reach[p]);
			eff = clamp_reach(phase_reach[p]);
			target = queued_beats + 250;
			while (queued_beats < target)
				queue_sequence(eff);
		end

		// Single-beat sequences while the receiver holds off, so the block backs up.
		wait_idle();
		write_reach(4'd1);
		hold_req <= ~hold_req;
		repeat (60) push_beat(draw_sample(FILL_WIDE), 1'b1);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && minimum_reports.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

/* filelist.f */
sv/fwsm_pkg.sv
sv/fwsm_in_if.sv
sv/fwsm_out_if.sv
sv/fwsm_cfg.sv
sv/fwsm_scan.sv
sv/first_window_strict_minimum_core.sv
sv/fwsm_checker.sv
dv/tb_top.sv
